@@ design/crs_pkg.sv @@
// Shared types, widths and codes for the channel range scaler.
package crs_pkg;

  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned CHAN_W       = 5;
  localparam int unsigned DATA_W       = 16;
  localparam int unsigned FRAC_W       = 14;
  localparam int unsigned QUO_W        = 17;
  localparam int unsigned DIVD_W       = 32;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_OUT = 2'd1,
    OP_IN  = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_UNI  = 2'd1,
    KIND_BI   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SAT    = 2'd1,
    ST_REJECT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ design/crs_if.sv @@
// Valid/ready channel interfaces for request and result words.
interface crs_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        operation;
  logic                              bank;
  logic [crs_pkg::CHAN_W-1:0]        channel;
  logic [1:0]                        range_kind;
  logic [crs_pkg::DATA_W-1:0]        range_low;
  logic [crs_pkg::DATA_W-1:0]        range_high;
  logic signed [crs_pkg::DATA_W-1:0] norm_in;
  logic [crs_pkg::DATA_W-1:0]        raw_in;

  modport source (
    output valid, operation, bank, channel, range_kind, range_low, range_high,
           norm_in, raw_in,
    input  ready
  );

  modport sink (
    input  valid, operation, bank, channel, range_kind, range_low, range_high,
           norm_in, raw_in,
    output ready
  );
endinterface

interface crs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [crs_pkg::DATA_W-1:0]        raw_out;
  logic signed [crs_pkg::DATA_W-1:0] norm_out;
  logic [1:0]                        status;

  modport source (
    output valid, raw_out, norm_out, status,
    input  ready
  );

  modport sink (
    input  valid, raw_out, norm_out, status,
    output ready
  );
endinterface

@@ design/crs_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module crs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crs_pkg::div_req_t req_i,
  output crs_pkg::div_rsp_t rsp_o
);
  import crs_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [QUO_W-1:0]  num_q, num_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  always_comb begin
    trial  = {rem_q, num_q[QUO_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W);
      rem_d  = DATA_W'(req_i.dividend[DIVD_W-1:QUO_W]);
      num_d  = req_i.dividend[QUO_W-1:0];
      dvs_d  = req_i.divisor;
      quo_d  = '0;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_d = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], ge};
        num_d = num_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = busy_q && (cnt_q == '0);
  assign rsp_o.quotient = quo_q;

endmodule

@@ design/channel_range_scaler.sv @@
// Range table and scaler: normalized <-> raw pulse width per channel.
// Set range, no-op, rejected or empty entries and far-out scale input go from accept
// through the calc and finish states; scale output adds a scaling state and scale
// input waits in a divide state for the 17-step divider. One word at a time: ready
// drops at accept and returns as the result enters the output register.
// Reset clears the per-entry valid flags, so every entry reads as kind none.
module channel_range_scaler #(
  parameter int unsigned CHANNELS = crs_pkg::CHANNELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crs_req_if.sink    req_i,
  crs_rsp_if.source  rsp_o
);
  import crs_pkg::*;

  localparam int unsigned DEPTH  = 2 * CHANNELS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [DATA_W-1:0] RAW_MAX  = 16'hFFFF;
  localparam logic [DATA_W-1:0] NORM_MAX = 16'h7FFF;
  localparam logic [DATA_W-1:0] NORM_MIN = 16'h8000;
  localparam logic [QUO_W-1:0]  QNEG_LIM = 17'd32768;
  localparam logic [QUO_W-1:0]  QPOS_LIM = 17'd32767;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CALC = 5'b00010,
    S_SCL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  entry_t range_mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  entry_t           rd_q;
  logic             rd_vld_q;

  logic              req_acc;
  logic              in_range;
  logic [ADDR_W-1:0] addr;
  logic              wr_en;
  entry_t            wr_ent;

  logic [1:0]        op_q;
  logic              rej_q;
  logic [DATA_W-1:0] norm_q;
  logic [DATA_W-1:0] raw_q;

  entry_t                  ent;
  logic                    is_uni, is_bi;
  logic signed [DATA_W:0]  span;
  logic signed [DATA_W:0]  mul_a;
  logic signed [33:0]      prod;
  logic [30:0]             off;
  logic signed [DATA_W:0]  dif;
  logic signed [18:0]      d19, s19, nnum, nneg;
  logic [17:0]             nmag;
  logic [DATA_W-1:0]       smag;
  logic [DATA_W:0]         sneg;
  logic                    big;
  logic                    go_div;

  logic signed [33:0] prod_q, prod_d;
  logic [30:0]        off_q, off_d;
  logic               bip_q, bip_d;
  logic               qneg_q, qneg_d;

  logic signed [34:0] sum, adj, shv;
  logic [QUO_W-1:0]   qn;

  logic [DATA_W-1:0] raw_res_q, raw_res_d;
  logic [DATA_W-1:0] norm_res_q, norm_res_d;
  logic [1:0]        st_res_q, st_res_d;

  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] out_raw_q, out_raw_d;
  logic [DATA_W-1:0] out_norm_q, out_norm_d;
  logic [1:0]        out_st_q, out_st_d;
  logic              out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  crs_div u_crs_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign in_range    = {1'b0, req_i.channel} < (CHAN_W + 1)'(CHANNELS);
  assign addr        = req_i.bank ? ADDR_W'(CHANNELS) + ADDR_W'(req_i.channel)
                                  : ADDR_W'(req_i.channel);
  assign wr_en       = req_acc && (req_i.operation == OP_SET) && in_range;
  assign wr_ent      = '{kind: req_i.range_kind, lo: req_i.range_low,
                         hi: req_i.range_high};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      range_mem[addr] <= wr_ent;
    end
    if (req_acc) begin
      rd_q <= range_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[addr] <= 1'b1;
      end
      if (req_acc) begin
        rd_vld_q <= vld_q[addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q   <= req_i.operation;
      rej_q  <= !in_range;
      norm_q <= req_i.norm_in;
      raw_q  <= req_i.raw_in;
    end
  end

  always_comb begin
    ent    = rd_vld_q ? rd_q : '0;
    is_uni = (ent.kind == KIND_UNI);
    is_bi  = (ent.kind == KIND_BI);
    span   = $signed({1'b0, ent.hi}) - $signed({1'b0, ent.lo});
    mul_a  = is_bi ? $signed({norm_q[DATA_W-1], norm_q}) + 17'sd16384
                   : $signed({norm_q[DATA_W-1], norm_q});
    prod   = 34'(mul_a) * 34'(span);
    off    = is_bi ? {ent.lo, 15'd0} : {1'b0, ent.lo, 14'd0};
    dif    = $signed({1'b0, raw_q}) - $signed({1'b0, ent.lo});
    d19    = {{2{dif[DATA_W]}}, dif};
    s19    = {{2{span[DATA_W]}}, span};
    nnum   = is_bi ? (d19 <<< 1) - s19 : d19;
    nneg   = -nnum;
    nmag   = nnum[18] ? nneg[17:0] : nnum[17:0];
    sneg   = -span;
    smag   = span[DATA_W] ? sneg[DATA_W-1:0] : span[DATA_W-1:0];
    big    = {1'b0, nmag} >= {smag, 3'b000};
    qneg_d = nnum[18] ^ span[DATA_W];
    prod_d = prod;
    off_d  = off;
    bip_d  = is_bi;
    go_div = (state_q == S_CALC) && (op_q == OP_IN) && !rej_q && (is_uni || is_bi)
             && (span != '0) && !big;
  end

  assign div_req.start    = go_div;
  assign div_req.dividend = {nmag, FRAC_W'(0)};
  assign div_req.divisor  = smag;

  always_comb begin
    sum = $signed({prod_q[33], prod_q}) + $signed({4'b0000, off_q});
    adj = sum[34] ? sum + (bip_q ? 35'sd32767 : 35'sd16383) : sum;
    shv = bip_q ? (adj >>> 15) : (adj >>> 14);
    qn  = -div_rsp.quotient;
  end

  assign out_free = !out_vld_q || rsp_o.ready;

  always_comb begin
    state_d    = state_q;
    raw_res_d  = raw_res_q;
    norm_res_d = norm_res_q;
    st_res_d   = st_res_q;
    out_vld_d  = out_vld_q;
    out_raw_d  = out_raw_q;
    out_norm_d = out_norm_q;
    out_st_d   = out_st_q;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        raw_res_d  = '0;
        norm_res_d = '0;
        st_res_d   = ST_OK;
        state_d    = S_FIN;
        priority if (op_q == OP_NOP) begin
          st_res_d = ST_OK;
        end else if (rej_q) begin
          st_res_d = ST_REJECT;
        end else if (op_q == OP_SET) begin
          st_res_d = ST_OK;
        end else if (!(is_uni || is_bi)) begin
          st_res_d = ST_EMPTY;
        end else if (op_q == OP_OUT) begin
          state_d = S_SCL;
        end else if (span == '0) begin
          st_res_d = ST_EMPTY;
        end else if (big) begin
          norm_res_d = qneg_d ? NORM_MIN : NORM_MAX;
          st_res_d   = ST_SAT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_SCL: begin
        if (shv[34]) begin
          raw_res_d = '0;
          st_res_d  = ST_SAT;
        end else if (|shv[33:DATA_W]) begin
          raw_res_d = RAW_MAX;
          st_res_d  = ST_SAT;
        end else begin
          raw_res_d = shv[DATA_W-1:0];
        end
        state_d = S_FIN;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (qneg_q) begin
            if (div_rsp.quotient > QNEG_LIM) begin
              norm_res_d = NORM_MIN;
              st_res_d   = ST_SAT;
            end else begin
              norm_res_d = qn[DATA_W-1:0];
            end
          end else begin
            if (div_rsp.quotient > QPOS_LIM) begin
              norm_res_d = NORM_MAX;
              st_res_d   = ST_SAT;
            end else begin
              norm_res_d = div_rsp.quotient[DATA_W-1:0];
            end
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_raw_d  = raw_res_q;
          out_norm_d = norm_res_q;
          out_st_d   = st_res_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) begin
      prod_q <= prod_d;
      off_q  <= off_d;
      bip_q  <= bip_d;
      qneg_q <= qneg_d;
    end
    raw_res_q  <= raw_res_d;
    norm_res_q <= norm_res_d;
    st_res_q   <= st_res_d;
    out_raw_q  <= out_raw_d;
    out_norm_q <= out_norm_d;
    out_st_q   <= out_st_d;
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.raw_out  = out_raw_q;
  assign rsp_o.norm_out = out_norm_q;
  assign rsp_o.status   = out_st_q;

endmodule

@@ design/crs_checker.sv @@
// Port-level assertions for the channel range scaler, bound to the top level.
module crs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [crs_pkg::DATA_W-1:0] raw_out_i,
  input logic [crs_pkg::DATA_W-1:0] norm_out_i,
  input logic [1:0]                 status_i
);
  import crs_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while a word is in flight");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(raw_out_i)
      && $stable(norm_out_i) && $stable(status_i))
    else $error("stalled result word changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_REJECT || status_i == ST_EMPTY)
      |-> raw_out_i == '0 && norm_out_i == '0)
    else $error("rejected or empty result carries data");

  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> raw_out_i == '0 || norm_out_i == '0)
    else $error("raw and normalized results both nonzero");

endmodule

bind channel_range_scaler crs_checker u_crs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_i.valid),
  .req_ready_i(req_i.ready),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .raw_out_i  (rsp_o.raw_out),
  .norm_out_i (rsp_o.norm_out),
  .status_i   (rsp_o.status)
);
